// ----- rtl/mms_pkg.sv -----
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and constants of the min/max stack.
// ----------------------------------------------------------------------------
package mms_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int COUNT_W = 7;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_OUT
    } t_state;

    typedef struct packed {
        logic vld;
        logic first;
    } t_scan_ctl;

endpackage

// ----- rtl/mms_ram.sv -----
// ----------------------------------------------------------------------------
// mms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/mms_scan.sv -----
// ----------------------------------------------------------------------------
// mms_scan
// Shared compare unit: folds one stored word per cycle into running max/min.
// ----------------------------------------------------------------------------
module mms_scan (
    input  logic                                 i_clk,
    input  mms_pkg::t_scan_ctl                   i_ctl,
    input  logic signed [mms_pkg::DATA_W-1:0]    i_data,
    output logic signed [mms_pkg::DATA_W-1:0]    o_max,
    output logic signed [mms_pkg::DATA_W-1:0]    o_min
);

    logic signed [mms_pkg::DATA_W-1:0] r_max;
    logic signed [mms_pkg::DATA_W-1:0] r_min;
    logic signed [mms_pkg::DATA_W-1:0] n_max;
    logic signed [mms_pkg::DATA_W-1:0] n_min;

    always_comb begin
        n_max = r_max;
        n_min = r_min;
        if (i_ctl.first) begin
            n_max = i_data;
            n_min = i_data;
        end else begin
            if (i_data > r_max) begin
                n_max = i_data;
            end
            if (i_data < r_min) begin
                n_min = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_max <= n_max;
            r_min <= n_min;
        end
    end

    assign o_max = r_max;
    assign o_min = r_min;

endmodule

// ----- rtl/stack_with_min_max_query_unit.sv -----
// ----------------------------------------------------------------------------
// stack_with_min_max_query_unit
// Bounded LIFO stack of signed words reporting count, max and min per request.
// ----------------------------------------------------------------------------
// One request is taken at a time. When a request is accepted (a push writes
// the stack RAM then), the stored words 0..N-1, N being the count held
// afterwards, are read one per cycle through the RAM read port into a single
// compare unit; the read data and its scan control are registered on the way.
// The scan is skipped when the stack ends up empty. The result stays on the
// output until taken; input stall is high meanwhile.
module stack_with_min_max_query_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_action,
    input  logic signed [mms_pkg::DATA_W-1:0]     i_push_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic        [mms_pkg::COUNT_W-1:0]    o_element_count,
    output logic signed [mms_pkg::DATA_W-1:0]     o_largest_value,
    output logic signed [mms_pkg::DATA_W-1:0]     o_smallest_value,
    output logic                                  o_push_dropped,
    output logic                                  o_pop_on_empty
);

    mms_pkg::t_state                 r_state;
    mms_pkg::t_state                 n_state;
    logic [mms_pkg::FILL_W-1:0]      r_fill;
    logic [mms_pkg::FILL_W-1:0]      n_fill;
    logic [mms_pkg::ADDR_W-1:0]      r_rd_addr;
    logic [mms_pkg::ADDR_W-1:0]      n_rd_addr;
    logic                            r_dropped;
    logic                            n_dropped;
    logic                            r_underflow;
    logic                            n_underflow;
    mms_pkg::t_scan_ctl              r_ctl;
    mms_pkg::t_scan_ctl              n_ctl;

    logic                            in_acc;
    logic                            is_full;
    logic                            is_empty;
    logic                            wr_en;
    logic                            rd_en;
    logic                            last_addr;
    logic [mms_pkg::DATA_W-1:0]      rd_data;
    logic signed [mms_pkg::DATA_W-1:0] scan_max;
    logic signed [mms_pkg::DATA_W-1:0] scan_min;

    assign in_acc    = i_in_valid && (r_state == mms_pkg::S_IDLE);
    assign is_full   = (r_fill == mms_pkg::FILL_W'(mms_pkg::DEPTH));
    assign is_empty  = (r_fill == '0);
    assign wr_en     = in_acc && (i_action == mms_pkg::ACT_PUSH) && !is_full;
    assign rd_en     = (r_state == mms_pkg::S_SCAN);
    assign last_addr = (mms_pkg::FILL_W'(r_rd_addr) == (r_fill - mms_pkg::FILL_W'(1)));

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_rd_addr   = r_rd_addr;
        n_dropped   = r_dropped;
        n_underflow = r_underflow;
        n_ctl.vld   = rd_en;
        n_ctl.first = (r_rd_addr == '0);
        case (r_state)
            mms_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_rd_addr   = '0;
                    n_dropped   = 1'b0;
                    n_underflow = 1'b0;
                    if (i_action == mms_pkg::ACT_PUSH) begin
                        if (is_full) begin
                            n_dropped = 1'b1;
                        end else begin
                            n_fill = r_fill + mms_pkg::FILL_W'(1);
                        end
                    end else begin
                        if (is_empty) begin
                            n_underflow = 1'b1;
                        end else begin
                            n_fill = r_fill - mms_pkg::FILL_W'(1);
                        end
                    end
                    n_state = (n_fill == '0) ? mms_pkg::S_OUT : mms_pkg::S_SCAN;
                end
            end
            mms_pkg::S_SCAN: begin
                n_rd_addr = r_rd_addr + mms_pkg::ADDR_W'(1);
                if (last_addr) begin
                    n_state = mms_pkg::S_LAST;
                end
            end
            mms_pkg::S_LAST: begin
                n_state = mms_pkg::S_OUT;
            end
            mms_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_state = mms_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mms_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mms_pkg::S_IDLE;
            r_fill  <= '0;
            r_ctl   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_dropped   <= n_dropped;
        r_underflow <= n_underflow;
    end

    mms_ram #(
        .WIDTH (mms_pkg::DATA_W),
        .DEPTH (mms_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[mms_pkg::ADDR_W-1:0]),
        .i_wr_data (i_push_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    mms_scan u_scan (
        .i_clk  (i_clk),
        .i_ctl  (r_ctl),
        .i_data (rd_data),
        .o_max  (scan_max),
        .o_min  (scan_min)
    );

    assign o_in_stall       = (r_state != mms_pkg::S_IDLE);
    assign o_out_valid      = (r_state == mms_pkg::S_OUT);
    assign o_element_count  = mms_pkg::COUNT_W'(r_fill);
    assign o_largest_value  = is_empty ? mms_pkg::EMPTY_VALUE : scan_max;
    assign o_smallest_value = is_empty ? mms_pkg::EMPTY_VALUE : scan_min;
    assign o_push_dropped   = r_dropped;
    assign o_pop_on_empty   = r_underflow;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= mms_pkg::FILL_W'(mms_pkg::DEPTH))
        else $error("fill level above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_fill == $past(r_fill) + mms_pkg::FILL_W'(1)))
        else $error("accepted push did not grow the stack");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_push_dropped && o_pop_on_empty))
        else $error("both error flags set on one result");

    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !is_empty) |-> (o_largest_value >= o_smallest_value))
        else $error("largest value below smallest value");
`endif

endmodule

// ----- tb/stack_with_min_max_query_unit_test.sv -----
// ----------------------------------------------------------------------------
// stack_with_min_max_query_unit_test
// Drives push and pop requests into the min/max stack with random idling on
// both channels. Every response is checked field by field against an internal
// copy of the stack. The run includes one long output hold-off, so the block
// holds its result and stalls its input.
// ----------------------------------------------------------------------------
module stack_with_min_max_query_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_TAIL    = 60;
    localparam int DRAIN_CYCLES  = 80;

    typedef struct packed {
        logic                              action;
        logic signed [mms_pkg::DATA_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic        [mms_pkg::COUNT_W-1:0] count;
        logic signed [mms_pkg::DATA_W-1:0]  largest;
        logic signed [mms_pkg::DATA_W-1:0]  smallest;
        logic                               dropped;
        logic                               underflow;
    } t_status;

    typedef enum logic [1:0] {
        FILL_BURST,
        DRAIN_BURST,
        MIXED_BURST
    } t_burst_kind;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic                                 i_action = mms_pkg::ACT_PUSH;
    logic signed [mms_pkg::DATA_W-1:0]    i_push_value = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic        [mms_pkg::COUNT_W-1:0]   o_element_count;
    logic signed [mms_pkg::DATA_W-1:0]    o_largest_value;
    logic signed [mms_pkg::DATA_W-1:0]    o_smallest_value;
    logic                                 o_push_dropped;
    logic                                 o_pop_on_empty;

    t_request                             request_queue[$];
    t_status                              expected_status[$];
    logic signed [mms_pkg::DATA_W-1:0]    stack_words[mms_pkg::DEPTH];
    int unsigned                          stack_fill = 0;

    int                                   total_requests = 0;
    int                                   requests_taken = 0;
    int                                   error_count = 0;
    int                                   cycle_count = 0;
    int                                   send_gap = 0;
    int                                   recv_gap = 0;
    int                                   long_hold_left = 0;
    logic                                 long_hold_done = 1'b0;
    t_status                              next_status;
    t_status                              want;

    stack_with_min_max_query_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_push_value     (i_push_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_element_count  (o_element_count),
        .o_largest_value  (o_largest_value),
        .o_smallest_value (o_smallest_value),
        .o_push_dropped   (o_push_dropped),
        .o_pop_on_empty   (o_pop_on_empty)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [mms_pkg::DATA_W-1:0] got,
                               input logic [mms_pkg::DATA_W-1:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
    endtask

    task automatic advance_stack(input t_request req, output t_status res);
        int unsigned                       k;
        logic signed [mms_pkg::DATA_W-1:0] hi;
        logic signed [mms_pkg::DATA_W-1:0] lo;
        res.dropped   = 1'b0;
        res.underflow = 1'b0;
        if (req.action == mms_pkg::ACT_PUSH) begin
            if (stack_fill < mms_pkg::DEPTH) begin
                stack_words[stack_fill] = req.value;
                stack_fill++;
            end else begin
                res.dropped = 1'b1;
            end
        end else if (stack_fill > 0) begin
            stack_fill--;
        end else begin
            res.underflow = 1'b1;
        end
        hi = mms_pkg::EMPTY_VALUE;
        lo = mms_pkg::EMPTY_VALUE;
        if (stack_fill > 0) begin
            hi = stack_words[0];
            lo = hi;
            for (k = 1; k < stack_fill; k++) begin
                if (stack_words[k] > hi) hi = stack_words[k];
                if (stack_words[k] < lo) lo = stack_words[k];
            end
        end
        res.count    = mms_pkg::COUNT_W'(stack_fill);
        res.largest  = hi;
        res.smallest = lo;
    endtask

    function automatic logic signed [mms_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 16)) - 8;
            3: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic queue_request(input logic action,
                                 input logic signed [mms_pkg::DATA_W-1:0] value);
        t_request req;
        req.action = action;
        req.value  = value;
        request_queue.push_back(req);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_stack(request_queue[0], next_status);
                expected_status.push_back(next_status);
                void'(request_queue.pop_front());
                requests_taken <= requests_taken + 1;
            end
            if (i_in_valid && o_in_stall) begin
                // stalled request stays as it is
            end else if (send_gap != 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (requests_taken + QUIET_TAIL < total_requests &&
                         $urandom_range(0, 9) == 0) begin
                send_gap   <= $urandom_range(0, 18);
                i_in_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                i_in_valid   <= 1'b1;
                i_action     <= request_queue[0].action;
                i_push_value <= request_queue[0].value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long output hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold_left <= 0;
            long_hold_done <= 1'b0;
        end else if (long_hold_left != 0) begin
            long_hold_left <= long_hold_left - 1;
        end else if (!long_hold_done && requests_taken >= 150) begin
            long_hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_gap    <= 0;
        end else if (recv_gap != 0) begin
            recv_gap    <= recv_gap - 1;
            i_out_stall <= 1'b1;
        end else if (requests_taken + QUIET_TAIL < total_requests &&
                     $urandom_range(0, 7) == 0) begin
            recv_gap    <= $urandom_range(0, 18);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (long_hold_left != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_status.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = expected_status.pop_front();
                check_field("element_count", mms_pkg::DATA_W'(o_element_count),
                            mms_pkg::DATA_W'(want.count));
                check_field("largest_value", o_largest_value, want.largest);
                check_field("smallest_value", o_smallest_value, want.smallest);
                check_field("push_dropped", mms_pkg::DATA_W'(o_push_dropped),
                            mms_pkg::DATA_W'(want.dropped));
                check_field("pop_on_empty", mms_pkg::DATA_W'(o_pop_on_empty),
                            mms_pkg::DATA_W'(want.underflow));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int          k;
        int          burst_len;
        t_burst_kind burst_kind;
        logic        do_push;

        // directed: empty pops, extremes, draining back to empty
        queue_request(mms_pkg::ACT_POP, 32'sh7FFF_FFFF);
        queue_request(mms_pkg::ACT_PUSH, 32'sh7FFF_FFFF);
        queue_request(mms_pkg::ACT_PUSH, 32'sh8000_0000);
        queue_request(mms_pkg::ACT_PUSH, -32'sd1);
        queue_request(mms_pkg::ACT_PUSH, 32'sd0);
        queue_request(mms_pkg::ACT_PUSH, 32'sd1);
        queue_request(mms_pkg::ACT_PUSH, 32'sh5555_AAAA);
        queue_request(mms_pkg::ACT_PUSH, 32'shAAAA_5555);
        for (k = 0; k < 7; k++)
            queue_request(mms_pkg::ACT_POP, $signed($urandom));
        queue_request(mms_pkg::ACT_POP, 32'sh8000_0000);
        queue_request(mms_pkg::ACT_PUSH, -32'sd1);
        queue_request(mms_pkg::ACT_POP, -32'sd1);
        queue_request(mms_pkg::ACT_PUSH, 32'sh8000_0000);
        queue_request(mms_pkg::ACT_PUSH, 32'sh8000_0000);
        queue_request(mms_pkg::ACT_POP, 32'sd0);
        queue_request(mms_pkg::ACT_POP, 32'sd0);

        // fill past full, then random bursts
        for (k = 0; k < mms_pkg::DEPTH + 6; k++)
            queue_request(mms_pkg::ACT_PUSH, random_value());
        while (request_queue.size() < 500) begin
            burst_len  = $urandom_range(10, 60);
            burst_kind = t_burst_kind'($urandom_range(0, 2));
            for (k = 0; k < burst_len; k++) begin
                case (burst_kind)
                    FILL_BURST:  do_push = ($urandom_range(0, 7) != 0);
                    DRAIN_BURST: do_push = ($urandom_range(0, 7) == 0);
                    default:     do_push = 1'($urandom_range(0, 1));
                endcase
                queue_request(do_push ? mms_pkg::ACT_PUSH : mms_pkg::ACT_POP,
                              random_value());
            end
        end
        total_requests = request_queue.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
